// ===== src/cmv_pkg.sv =====
// cmv_pkg: shared types and constants of the colormap block.
// Used by the channel interfaces and the top level.
package cmv_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int CLS_BITS    = 32;      // class index width, one remainder bit per stage
   localparam int DIV_STEPS   = 17;      // quotient bits of the position divider
   localparam int CSR_AW      = 5;       // eight 32-bit registers
   localparam int RGB_W       = 24;

   // palette position constants, Q1.16
   localparam logic [DIV_STEPS-1:0] POS_ONE  = 17'h10000;
   localparam logic [DIV_STEPS-1:0] POS_HALF = 17'h08000;

   localparam logic signed [31:0] RST_LOW    = 32'sd0;
   localparam logic signed [31:0] RST_MIDDLE = 32'sd32768;
   localparam logic signed [31:0] RST_HIGH   = 32'sd65536;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_QUAL  = 2'd1,
      OP_SEQ   = 2'd2,
      OP_DIV   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_MAPPED    = 4'd0,
      ST_EMPTY     = 4'd1,
      ST_SINGLE    = 4'd2,
      ST_MASKED    = 4'd3,
      ST_BELOW     = 4'd4,
      ST_ABOVE     = 4'd5,
      ST_LO_HI     = 4'd6,
      ST_LO_MID    = 4'd7,
      ST_MID_HI    = 4'd8,
      ST_WRITE_ACK = 4'd9
   } status_type;

   // how the result color is formed
   typedef enum logic [1:0] {
      K_FIXED = 2'd0,   // color carried with the item
      K_CLASS = 2'd1,   // entry at class remainder
      K_FIRST = 2'd2,   // entry zero
      K_BLEND = 2'd3    // interpolated between two entries
   } kind_type;

   typedef enum logic [1:0] {
      POS_FULL  = 2'd0,
      POS_LOWER = 2'd1,
      POS_UPPER = 2'd2
   } pos_type;

   typedef enum logic [2:0] {
      REG_LOW    = 3'd0,
      REG_MIDDLE = 3'd1,
      REG_HIGH   = 3'd2,
      REG_MASKED = 3'd3,
      REG_CLAMP  = 3'd4,
      REG_MASK   = 3'd5,
      REG_BELOW  = 3'd6,
      REG_ABOVE  = 3'd7
   } reg_type;

endpackage

// ===== src/cmv_if.sv =====
// cmv_req_if / cmv_rsp_if: valid/ready channels of the colormap block.
// Depends on cmv_pkg for the operation type.
interface cmv_req_if;
   logic                valid;
   logic                ready;
   cmv_pkg::op_type     operation;
   logic [7:0]          entry_slot;
   logic [23:0]         entry_rgb;
   logic                final_entry;
   logic [31:0]         class_index;
   logic signed [31:0]  sample_value;
   logic                sample_not_finite;

   modport source (output valid, operation, entry_slot, entry_rgb, final_entry,
                   class_index, sample_value, sample_not_finite, input ready);
   modport sink   (input valid, operation, entry_slot, entry_rgb, final_entry,
                   class_index, sample_value, sample_not_finite, output ready);
endinterface

interface cmv_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [3:0] status;

   modport source (output valid, red, green, blue, status, input ready);
   modport sink   (input valid, red, green, blue, status, output ready);
endinterface

// ===== src/cmv_ram.sv =====
// cmv_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module cmv_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/colormap_value_to_rgb.sv =====
// colormap_value_to_rgb: palette lookup with linear interpolation, top level.
// Depends on cmv_pkg, cmv_req_if / cmv_rsp_if and cmv_ram.
//
//   channel   dir  handshake        carries
//   req       in   valid/ready      operation, palette write, class index, sample
//   rsp       out  valid/ready      red, green, blue, status
//   csr_*     in   APB write/read   range, mask, clamp and fallback colors
//
// One item per cycle while rsp.ready holds. Stages: one check stage, 32 stages that each
// retire one bit of the class remainder and (first 17) one bit of the position
// quotient, then position scaling, palette read, blend products, output register.
// Every stage stalls only when its successor is full, so bubbles close up.
// Palette writes reach the RAM in item order at the read stage; the entry count
// updates on acceptance. Synchronous reset clears control state only.
module colormap_value_to_rgb #(
   parameter int MAX_ENTRIES = cmv_pkg::MAX_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   cmv_req_if.sink                     req,
   cmv_rsp_if.source                   rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cmv_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int NS = cmv_pkg::CLS_BITS;
   localparam int QW = cmv_pkg::DIV_STEPS;
   localparam int EW = CW + QW;
   localparam int RW = cmv_pkg::RGB_W;

   typedef struct packed {
      cmv_pkg::status_type st;
      cmv_pkg::kind_type   kind;
      cmv_pkg::pos_type    pmode;
      logic [RW-1:0]       rgb;
      logic [31:0]         den;
      logic [31:0]         cls;
      logic [CW-1:0]       cnt;
      logic                wr;
      logic [AW-1:0]       slot;
      logic [RW-1:0]       wdata;
   } item_type;

   // ---------------- configuration registers
   logic signed [31:0] low_ff, middle_ff, high_ff, masked_ff;
   logic               clamp_ff;
   logic [RW-1:0]      mask_rgb_ff, below_rgb_ff, above_rgb_ff;
   logic               csr_wr;
   cmv_pkg::reg_type   csr_reg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = cmv_pkg::reg_type'(csr_paddr[cmv_pkg::CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= cmv_pkg::RST_LOW;
         middle_ff    <= cmv_pkg::RST_MIDDLE;
         high_ff      <= cmv_pkg::RST_HIGH;
         masked_ff    <= '0;
         clamp_ff     <= 1'b0;
         mask_rgb_ff  <= '0;
         below_rgb_ff <= '0;
         above_rgb_ff <= '0;
      end else if (csr_wr) begin
         case (csr_reg)
            cmv_pkg::REG_LOW:    low_ff       <= signed'(csr_pwdata);
            cmv_pkg::REG_MIDDLE: middle_ff    <= signed'(csr_pwdata);
            cmv_pkg::REG_HIGH:   high_ff      <= signed'(csr_pwdata);
            cmv_pkg::REG_MASKED: masked_ff    <= signed'(csr_pwdata);
            cmv_pkg::REG_CLAMP:  clamp_ff     <= csr_pwdata[0];
            cmv_pkg::REG_MASK:   mask_rgb_ff  <= csr_pwdata[RW-1:0];
            cmv_pkg::REG_BELOW:  below_rgb_ff <= csr_pwdata[RW-1:0];
            cmv_pkg::REG_ABOVE:  above_rgb_ff <= csr_pwdata[RW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         cmv_pkg::REG_LOW:    csr_prdata = low_ff;
         cmv_pkg::REG_MIDDLE: csr_prdata = middle_ff;
         cmv_pkg::REG_HIGH:   csr_prdata = high_ff;
         cmv_pkg::REG_MASKED: csr_prdata = masked_ff;
         cmv_pkg::REG_CLAMP:  csr_prdata = {31'd0, clamp_ff};
         cmv_pkg::REG_MASK:   csr_prdata = {8'd0, mask_rgb_ff};
         cmv_pkg::REG_BELOW:  csr_prdata = {8'd0, below_rgb_ff};
         cmv_pkg::REG_ABOVE:  csr_prdata = {8'd0, above_rgb_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // ---------------- stage handshake chain
   logic mv     [0:NS];
   logic mv_e, mv_m, mv_p, mv_out;
   logic e_v_ff, m_v_ff, p_v_ff, out_v_ff;
   logic d_v_ff [0:NS];

   assign mv_out = !out_v_ff || rsp.ready;
   assign mv_p   = !p_v_ff || mv_out;
   assign mv_m   = !m_v_ff || mv_p;
   assign mv_e   = !e_v_ff || mv_m;

   genvar k;
   for (k = 0; k < NS; k++) begin : g_mv
      assign mv[k] = !d_v_ff[k] || mv[k+1];
   end
   assign mv[NS] = !d_v_ff[NS] || mv_e;

   assign req.ready = mv[0];

   // ---------------- check stage (loads stage 0 on acceptance)
   logic              req_fire, slot_ok;
   logic [CW-1:0]     cnt_ff;
   logic signed [31:0] vcl;
   logic signed [32:0] d_lo, d_mid, den_full, den_low, den_up;
   item_type          s0_in;
   logic [31:0]       num_in;

   assign req_fire = req.valid && mv[0];
   assign slot_ok  = 32'(req.entry_slot) < 32'(MAX_ENTRIES);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (req_fire && req.operation == cmv_pkg::OP_WRITE && slot_ok
                   && req.final_entry) begin
         cnt_ff <= CW'(req.entry_slot) + CW'(1);
      end
   end

   always_comb begin
      vcl = req.sample_value;
      if (clamp_ff) begin
         if (vcl < low_ff)  vcl = low_ff;
         if (vcl > high_ff) vcl = high_ff;
      end
   end

   assign d_lo     = 33'(vcl) - 33'(low_ff);
   assign d_mid    = 33'(vcl) - 33'(middle_ff);
   assign den_full = 33'(high_ff) - 33'(low_ff);
   assign den_low  = 33'(middle_ff) - 33'(low_ff);
   assign den_up   = 33'(high_ff) - 33'(middle_ff);

   always_comb begin
      s0_in       = '0;
      num_in      = '0;
      s0_in.cls   = req.class_index;
      s0_in.cnt   = cnt_ff;
      s0_in.slot  = AW'(req.entry_slot);
      s0_in.wdata = req.entry_rgb;
      s0_in.kind  = cmv_pkg::K_FIXED;
      s0_in.pmode = cmv_pkg::POS_FULL;
      s0_in.st    = cmv_pkg::ST_MAPPED;
      if (req.operation == cmv_pkg::OP_WRITE) begin
         s0_in.st = cmv_pkg::ST_WRITE_ACK;
         s0_in.wr = slot_ok;
      end else if (cnt_ff == '0) begin
         s0_in.st = cmv_pkg::ST_EMPTY;
      end else if (req.operation == cmv_pkg::OP_QUAL) begin
         s0_in.kind = cmv_pkg::K_CLASS;
      end else if (cnt_ff == CW'(1)) begin
         s0_in.st   = cmv_pkg::ST_SINGLE;
         s0_in.kind = cmv_pkg::K_FIRST;
      end else if (low_ff >= high_ff) begin
         s0_in.st = cmv_pkg::ST_LO_HI;
      end else if (low_ff >= middle_ff) begin
         s0_in.st = cmv_pkg::ST_LO_MID;
      end else if (middle_ff >= high_ff) begin
         s0_in.st = cmv_pkg::ST_MID_HI;
      end else if (req.sample_not_finite || req.sample_value == masked_ff) begin
         s0_in.st  = cmv_pkg::ST_MASKED;
         s0_in.rgb = mask_rgb_ff;
      end else if (vcl < low_ff) begin
         s0_in.st  = cmv_pkg::ST_BELOW;
         s0_in.rgb = below_rgb_ff;
      end else if (vcl > high_ff) begin
         s0_in.st  = cmv_pkg::ST_ABOVE;
         s0_in.rgb = above_rgb_ff;
      end else begin
         s0_in.kind = cmv_pkg::K_BLEND;
         if (req.operation == cmv_pkg::OP_SEQ) begin
            num_in    = d_lo[31:0];
            s0_in.den = den_full[31:0];
         end else if (vcl < middle_ff) begin
            s0_in.pmode = cmv_pkg::POS_LOWER;
            num_in      = d_lo[31:0];
            s0_in.den   = den_low[31:0];
         end else begin
            s0_in.pmode = cmv_pkg::POS_UPPER;
            num_in      = d_mid[31:0];
            s0_in.den   = den_up[31:0];
         end
      end
   end

   // ---------------- remainder / quotient stages
   item_type      d_item_ff [0:NS];
   logic [CW-1:0] d_rem_ff  [0:NS];
   logic [31:0]   d_r_ff    [0:NS];
   logic [QW-1:0] d_q_ff    [0:NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff[0] <= 1'b0;
      end else if (mv[0]) begin
         d_v_ff[0] <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mv[0]) begin
         d_item_ff[0] <= s0_in;
         d_rem_ff[0]  <= '0;
         d_r_ff[0]    <= num_in;
         d_q_ff[0]    <= '0;
      end
   end

   for (k = 1; k <= NS; k++) begin : g_step
      logic [CW:0]   rem2;
      logic [CW-1:0] rem_in;
      logic [32:0]   r2;
      logic          qbit;
      logic [31:0]   r_in;
      logic [QW-1:0] q_in;

      assign rem2   = {d_rem_ff[k-1], d_item_ff[k-1].cls[NS-k]};
      assign rem_in = (rem2 >= {1'b0, d_item_ff[k-1].cnt})
                      ? CW'(rem2 - {1'b0, d_item_ff[k-1].cnt}) : CW'(rem2);

      if (k <= QW) begin : g_div
         // first step takes the numerator unshifted (it never exceeds the divisor)
         assign r2   = (k == 1) ? {1'b0, d_r_ff[k-1]} : {d_r_ff[k-1], 1'b0};
         assign qbit = r2 >= {1'b0, d_item_ff[k-1].den};
         assign r_in = qbit ? 32'(r2 - {1'b0, d_item_ff[k-1].den}) : r2[31:0];
         assign q_in = {d_q_ff[k-1][QW-2:0], qbit};
      end else begin : g_pass
         assign r2   = '0;
         assign qbit = 1'b0;
         assign r_in = d_r_ff[k-1];
         assign q_in = d_q_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_v_ff[k] <= 1'b0;
         end else if (mv[k]) begin
            d_v_ff[k] <= d_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (mv[k]) begin
            d_item_ff[k] <= d_item_ff[k-1];
            d_rem_ff[k]  <= rem_in;
            d_r_ff[k]    <= r_in;
            d_q_ff[k]    <= q_in;
         end
      end
   end

   // ---------------- position scaling
   item_type      e_item_ff;
   logic [AW-1:0] e_ia_ff, ia_in;
   logic [15:0]   e_f_ff, f_in;
   logic [QW-1:0] pos;
   logic [EW-1:0] epos;

   always_comb begin
      case (d_item_ff[NS].pmode)
         cmv_pkg::POS_LOWER: pos = {1'b0, d_q_ff[NS][QW-1:1]};
         cmv_pkg::POS_UPPER: pos = cmv_pkg::POS_HALF + {1'b0, d_q_ff[NS][QW-1:1]};
         default:            pos = d_q_ff[NS];
      endcase
      if (pos > cmv_pkg::POS_ONE) pos = cmv_pkg::POS_ONE;
   end

   assign epos = EW'(d_item_ff[NS].cnt - CW'(1)) * EW'(pos);

   always_comb begin
      case (d_item_ff[NS].kind)
         cmv_pkg::K_CLASS: begin
            ia_in = AW'(d_rem_ff[NS]);
            f_in  = '0;
         end
         cmv_pkg::K_BLEND: begin
            ia_in = AW'(epos[EW-1:16]);
            f_in  = epos[15:0];
         end
         default: begin
            ia_in = '0;
            f_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (mv_e) begin
         e_v_ff <= d_v_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (mv_e) begin
         e_item_ff <= d_item_ff[NS];
         e_ia_ff   <= ia_in;
         e_f_ff    <= f_in;
      end
   end

   // ---------------- palette access: two copies give entries i and i+1 together
   logic          pal_wr;
   logic [RW-1:0] a_rd, b_rd;

   assign pal_wr = e_v_ff && e_item_ff.wr && mv_m;

   cmv_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_pal_a (
      .clock   (clock),
      .wr_en   (pal_wr),
      .wr_addr (e_item_ff.slot),
      .wr_data (e_item_ff.wdata),
      .rd_en   (mv_m),
      .rd_addr (e_ia_ff),
      .rd_data (a_rd)
   );

   cmv_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_pal_b (
      .clock   (clock),
      .wr_en   (pal_wr),
      .wr_addr (e_item_ff.slot),
      .wr_data (e_item_ff.wdata),
      .rd_en   (mv_m),
      .rd_addr (e_ia_ff + AW'(1)),
      .rd_data (b_rd)
   );

   cmv_pkg::status_type m_st_ff;
   logic                m_fixed_ff;
   logic [RW-1:0]       m_rgb_ff;
   logic [15:0]         m_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (mv_m) begin
         m_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mv_m) begin
         m_st_ff    <= e_item_ff.st;
         m_fixed_ff <= e_item_ff.kind == cmv_pkg::K_FIXED;
         m_rgb_ff   <= e_item_ff.rgb;
         m_f_ff     <= e_f_ff;
      end
   end

   // ---------------- blend products; f of zero returns entry a exactly
   logic [2:0][24:0]    pa_in, pb_in;
   logic [2:0][24:0]    p_pa_ff, p_pb_ff;
   logic [16:0]         wf;
   cmv_pkg::status_type p_st_ff;
   logic                p_fixed_ff;
   logic [RW-1:0]       p_rgb_ff;

   assign wf = cmv_pkg::POS_ONE - {1'b0, m_f_ff};

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         pa_in[c] = 25'(a_rd[RW-1-8*c -: 8] * wf);
         pb_in[c] = 25'(b_rd[RW-1-8*c -: 8] * m_f_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (mv_p) begin
         p_v_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mv_p) begin
         p_pa_ff    <= pa_in;
         p_pb_ff    <= pb_in;
         p_st_ff    <= m_st_ff;
         p_fixed_ff <= m_fixed_ff;
         p_rgb_ff   <= m_rgb_ff;
      end
   end

   // ---------------- round, select, output register
   logic [RW-1:0] rgb_in, out_rgb_ff;
   logic [24:0]   sum;
   logic [3:0]    out_st_ff;

   always_comb begin
      sum    = '0;
      rgb_in = p_rgb_ff;
      if (!p_fixed_ff) begin
         for (int c = 0; c < 3; c++) begin
            sum = p_pa_ff[c] + p_pb_ff[c] + 25'h8000;   // round half up
            rgb_in[RW-1-8*c -: 8] = sum[23:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (mv_out) begin
         out_v_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mv_out) begin
         out_rgb_ff <= rgb_in;
         out_st_ff  <= p_st_ff;
      end
   end

   assign rsp.valid  = out_v_ff;
   assign rsp.red    = out_rgb_ff[23:16];
   assign rsp.green  = out_rgb_ff[15:8];
   assign rsp.blue   = out_rgb_ff[7:0];
   assign rsp.status = out_st_ff;

endmodule
